### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication with a fixed delay between antecedent and consequent.
`define AST_DLY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error("assertion failed");

`endif

### rtl/vav_pkg.sv
package vav_pkg;

  localparam int NORM_BITS    = 15;
  localparam int VEC_W        = 16;
  localparam int PROD_W       = 32;
  localparam int DOT_W        = 34;
  localparam int CMAG_W       = 32;
  localparam int CSQ_W        = 64;
  localparam int ROOT_W       = 32;
  localparam int ZFRAC        = 30;
  localparam int CORDIC_STEPS = 28;
  localparam int XY_W         = 36;
  localparam int Z_W          = 34;

  localparam logic [Z_W-1:0] HALF_PI_Q = 34'd1686629713;
  localparam logic [Z_W-1:0] PI_Q      = 34'd3373259426;

  localparam int NORM_LAT   = 3;
  localparam int PROD_LAT   = 4;
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int TOTAL_LAT  = NORM_LAT + PROD_LAT + ROOT_W + CORDIC_LAT;

  typedef struct packed {
    logic valid;
    logic degen;
  } ctl_t;

  function automatic logic [Z_W-1:0] atan_q(input int i);
    logic [Z_W-1:0] r;
    case (i)
      0:       r = 34'd843314857;
      1:       r = 34'd497837829;
      2:       r = 34'd263043837;
      3:       r = 34'd133525159;
      4:       r = 34'd67021687;
      5:       r = 34'd33543516;
      6:       r = 34'd16775851;
      7:       r = 34'd8388437;
      8:       r = 34'd4194283;
      9:       r = 34'd2097149;
      default: r = (i < 30) ? (Z_W'(1) << (30 - i)) : '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/vav_norm.sv
module vav_norm import vav_pkg::*; #(
  parameter int CW = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  planar,
  input  logic [2:0][CW-1:0]    first,
  input  logic [2:0][CW-1:0]    vertex,
  input  logic [2:0][CW-1:0]    third,
  output ctl_t                  ctl,
  output logic [2:0][VEC_W-1:0] u_vec,
  output logic [2:0][VEC_W-1:0] v_vec
);

  localparam int MSB_W = $clog2(CW);
  localparam int SH_W  = $clog2(CW + 1);
  localparam int EXT_W = CW + NORM_BITS;

  logic [2:0][CW:0]   du_nxt, dv_nxt;
  logic [2:0][CW-1:0] mu_nxt, mv_nxt;
  logic [2:0][CW-1:0] mu1_r, mv1_r, mu2_r, mv2_r;
  logic [2:0]         nu1_r, nv1_r, nu2_r, nv2_r;
  logic               v1_r, v2_r, v3_r;
  logic [CW-1:0]      oru, orv;
  logic [MSB_W-1:0]   msbu_nxt, msbv_nxt, msbu_r, msbv_r;
  logic               nzu_r, nzv_r, dg3_r;
  logic [2:0][VEC_W-1:0] u_r, v_r;
  logic [2:0][VEC_W-1:0] u_nxt, v_nxt;
  logic [EXT_W-1:0]   extu, extv;
  logic [SH_W-1:0]    shu, shv;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      du_nxt[k] = {first[k][CW-1], first[k]} - {vertex[k][CW-1], vertex[k]};
      dv_nxt[k] = {third[k][CW-1], third[k]} - {vertex[k][CW-1], vertex[k]};
      if (planar && k == 2) begin
        du_nxt[k] = '0;
        dv_nxt[k] = '0;
      end
      mu_nxt[k] = du_nxt[k][CW] ? CW'(-du_nxt[k]) : du_nxt[k][CW-1:0];
      mv_nxt[k] = dv_nxt[k][CW] ? CW'(-dv_nxt[k]) : dv_nxt[k][CW-1:0];
    end
  end

  always_comb begin
    oru = mu1_r[0] | mu1_r[1] | mu1_r[2];
    orv = mv1_r[0] | mv1_r[1] | mv1_r[2];
    msbu_nxt = '0;
    msbv_nxt = '0;
    for (int j = 0; j < CW; j++) begin
      if (oru[j]) msbu_nxt = MSB_W'(j);
      if (orv[j]) msbv_nxt = MSB_W'(j);
    end
  end

  always_comb begin
    shu = SH_W'(msbu_r) + SH_W'(1);
    shv = SH_W'(msbv_r) + SH_W'(1);
    for (int k = 0; k < 3; k++) begin
      extu = {mu2_r[k], {NORM_BITS{1'b0}}} >> shu;
      extv = {mv2_r[k], {NORM_BITS{1'b0}}} >> shv;
      u_nxt[k] = nu2_r[k] ? VEC_W'(0) - {1'b0, extu[NORM_BITS-1:0]}
                          : {1'b0, extu[NORM_BITS-1:0]};
      v_nxt[k] = nv2_r[k] ? VEC_W'(0) - {1'b0, extv[NORM_BITS-1:0]}
                          : {1'b0, extv[NORM_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mu1_r[k] <= mu_nxt[k];
      mv1_r[k] <= mv_nxt[k];
      nu1_r[k] <= du_nxt[k][CW];
      nv1_r[k] <= dv_nxt[k][CW];
    end
    mu2_r  <= mu1_r;
    mv2_r  <= mv1_r;
    nu2_r  <= nu1_r;
    nv2_r  <= nv1_r;
    msbu_r <= msbu_nxt;
    msbv_r <= msbv_nxt;
    nzu_r  <= |oru;
    nzv_r  <= |orv;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    dg3_r  <= !(nzu_r && nzv_r);
  end

  assign ctl.valid = v3_r;
  assign ctl.degen = dg3_r;
  assign u_vec     = u_r;
  assign v_vec     = v_r;

endmodule

### rtl/vav_prod.sv
module vav_prod import vav_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_t                  ctl_in,
  input  logic [2:0][VEC_W-1:0] u_vec,
  input  logic [2:0][VEC_W-1:0] v_vec,
  output ctl_t                  ctl_out,
  output logic [DOT_W-1:0]      dot,
  output logic [CSQ_W-1:0]      csq
);

  logic signed [PROD_W-1:0] pd_r [3];
  logic signed [PROD_W-1:0] pc_r [6];
  logic [DOT_W-1:0]   dot2_r, dot3_r, dot4_r;
  logic [2:0][CMAG_W-1:0] cm_r;
  logic [2:0][CSQ_W-1:0]  sq_r;
  logic [CSQ_W-1:0]   csq_r;
  logic signed [DOT_W-1:0] cd_nxt [3];
  logic [2:0][CMAG_W-1:0]  cm_nxt;
  logic [CSQ_W+1:0]   csq_nxt;
  ctl_t               c1_r, c2_r, c3_r, c4_r;

  always_comb begin
    cd_nxt[0] = DOT_W'(pc_r[0]) - DOT_W'(pc_r[1]);
    cd_nxt[1] = DOT_W'(pc_r[2]) - DOT_W'(pc_r[3]);
    cd_nxt[2] = DOT_W'(pc_r[4]) - DOT_W'(pc_r[5]);
    for (int k = 0; k < 3; k++) begin
      cm_nxt[k] = cd_nxt[k][DOT_W-1] ? CMAG_W'(-cd_nxt[k]) : CMAG_W'(cd_nxt[k]);
    end
    csq_nxt = (CSQ_W + 2)'(sq_r[0]) + (CSQ_W + 2)'(sq_r[1]) + (CSQ_W + 2)'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
    end else begin
      c1_r <= ctl_in;
      c2_r <= c1_r;
      c3_r <= c2_r;
      c4_r <= c3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pd_r[k] <= $signed(u_vec[k]) * $signed(v_vec[k]);
    end
    pc_r[0] <= $signed(u_vec[1]) * $signed(v_vec[2]);
    pc_r[1] <= $signed(u_vec[2]) * $signed(v_vec[1]);
    pc_r[2] <= $signed(u_vec[2]) * $signed(v_vec[0]);
    pc_r[3] <= $signed(u_vec[0]) * $signed(v_vec[2]);
    pc_r[4] <= $signed(u_vec[0]) * $signed(v_vec[1]);
    pc_r[5] <= $signed(u_vec[1]) * $signed(v_vec[0]);
    dot2_r  <= DOT_W'(pd_r[0]) + DOT_W'(pd_r[1]) + DOT_W'(pd_r[2]);
    cm_r    <= cm_nxt;
    dot3_r  <= dot2_r;
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= CSQ_W'(cm_r[k]) * CSQ_W'(cm_r[k]);
    end
    dot4_r  <= dot3_r;
    csq_r   <= csq_nxt[CSQ_W-1:0];
  end

  assign ctl_out = c4_r;
  assign dot     = dot4_r;
  assign csq     = csq_r;

endmodule

### rtl/vav_isqrt.sv
module vav_isqrt import vav_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl_in,
  input  logic [DOT_W-1:0]  dot_in,
  input  logic [CSQ_W-1:0]  csq,
  output ctl_t              ctl_out,
  output logic [DOT_W-1:0]  dot_out,
  output logic [ROOT_W-1:0] root
);

  localparam int RW = CSQ_W + 2;

  ctl_t              ctl_s [ROOT_W+1];
  logic [DOT_W-1:0]  dot_s [ROOT_W+1];
  logic [RW-1:0]     rem_s [ROOT_W+1];
  logic [ROOT_W-1:0] q_s   [ROOT_W+1];

  assign ctl_s[0] = ctl_in;
  assign dot_s[0] = dot_in;
  assign rem_s[0] = RW'(csq);
  assign q_s[0]   = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam int I = ROOT_W - 1 - k;
    logic [RW-1:0]     trial;
    logic [RW-1:0]     rem_nxt, rem_r;
    logic [ROOT_W-1:0] q_nxt, q_r;
    logic [DOT_W-1:0]  dot_r;
    ctl_t              ctl_r;

    always_comb begin
      trial = (RW'(q_s[k]) << (I + 1)) + (RW'(1) << (2 * I));
      if (rem_s[k] >= trial) begin
        rem_nxt = rem_s[k] - trial;
        q_nxt   = q_s[k] | (ROOT_W'(1) << I);
      end else begin
        rem_nxt = rem_s[k];
        q_nxt   = q_s[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r <= '0;
      end else begin
        ctl_r <= ctl_s[k];
      end
    end

    always_ff @(posedge clk) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      dot_r <= dot_s[k];
    end

    assign ctl_s[k+1] = ctl_r;
    assign dot_s[k+1] = dot_r;
    assign rem_s[k+1] = rem_r;
    assign q_s[k+1]   = q_r;
  end

  assign ctl_out = ctl_s[ROOT_W];
  assign dot_out = dot_s[ROOT_W];
  assign root    = q_s[ROOT_W];

endmodule

### rtl/vav_cordic.sv
module vav_cordic import vav_pkg::*; #(
  parameter int AF = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl_in,
  input  logic [DOT_W-1:0]  dot,
  input  logic [ROOT_W-1:0] root,
  output logic              out_valid,
  output logic [AF+1:0]     angle,
  output logic              degenerate
);

  ctl_t                   ctl_s [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] x_s   [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] y_s   [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  z_s   [CORDIC_STEPS+1];

  logic signed [XY_W-1:0] x0_nxt, y0_nxt;
  logic signed [Z_W-1:0]  z0_nxt;
  ctl_t                   c0_r;
  logic signed [XY_W-1:0] x0_r, y0_r;
  logic signed [Z_W-1:0]  z0_r;

  always_comb begin
    if (dot[DOT_W-1]) begin
      x0_nxt = XY_W'(root);
      y0_nxt = XY_W'($signed(-dot));
      z0_nxt = HALF_PI_Q;
    end else begin
      x0_nxt = XY_W'($signed(dot));
      y0_nxt = XY_W'(root);
      z0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r <= '0;
    end else begin
      c0_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    x0_r <= x0_nxt;
    y0_r <= y0_nxt;
    z0_r <= z0_nxt;
  end

  assign ctl_s[0] = c0_r;
  assign x_s[0]   = x0_r;
  assign y_s[0]   = y0_r;
  assign z_s[0]   = z0_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [XY_W-1:0] xs, ys, x_nxt, y_nxt, x_r, y_r;
    logic signed [Z_W-1:0]  z_nxt, z_r;
    ctl_t                   ctl_r;

    always_comb begin
      xs = x_s[i] >>> i;
      ys = y_s[i] >>> i;
      if (y_s[i] > 0) begin
        x_nxt = x_s[i] + ys;
        y_nxt = y_s[i] - xs;
        z_nxt = z_s[i] + $signed(atan_q(i));
      end else begin
        x_nxt = x_s[i] - ys;
        y_nxt = y_s[i] + xs;
        z_nxt = z_s[i] - $signed(atan_q(i));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r <= '0;
      end else begin
        ctl_r <= ctl_s[i];
      end
    end

    always_ff @(posedge clk) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end

    assign ctl_s[i+1] = ctl_r;
    assign x_s[i+1]   = x_r;
    assign y_s[i+1]   = y_r;
    assign z_s[i+1]   = z_r;
  end

  logic signed [Z_W-1:0] zf;
  logic [Z_W-1:0]        zc, zsum;
  logic [AF+1:0]         angle_nxt, angle_r;
  logic                  valid_r, degen_r;

  assign zf = z_s[CORDIC_STEPS];

  always_comb begin
    if (zf < 0) begin
      zc = '0;
    end else if (zf > $signed(PI_Q)) begin
      zc = PI_Q;
    end else begin
      zc = zf;
    end
    zsum      = zc + (Z_W'(1) << (ZFRAC - AF - 1));
    angle_nxt = ctl_s[CORDIC_STEPS].degen ? '0 : zsum[ZFRAC+1:ZFRAC-AF];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_s[CORDIC_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
    degen_r <= ctl_s[CORDIC_STEPS].degen;
  end

  assign out_valid  = valid_r;
  assign angle      = angle_r;
  assign degenerate = degen_r;

endmodule

### rtl/vector_angle_at_vertex.sv
// Angle at a vertex between the vectors to two other points, in radians with
// ANGLE_FRAC_BITS fraction bits, from 0 to pi. The block is fully pipelined:
// a new point triple may start in every clock cycle, and its result appears
// on out_valid after passing through three normalize stages, four product
// stages, a 32-stage square root of the cross-product norm and a 28-step
// CORDIC with entry and rounding stages. busy is high only during reset.
// Results cannot be stalled, so the receiver must take each one in the
// cycle it is shown.
`include "assert_macros.svh"

module vector_angle_at_vertex import vav_pkg::*; #(
  parameter int COORD_WIDTH     = 24,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [COORD_WIDTH-1:0]       in_first_x,
  input  logic [COORD_WIDTH-1:0]       in_first_y,
  input  logic [COORD_WIDTH-1:0]       in_first_z,
  input  logic [COORD_WIDTH-1:0]       in_vertex_x,
  input  logic [COORD_WIDTH-1:0]       in_vertex_y,
  input  logic [COORD_WIDTH-1:0]       in_vertex_z,
  input  logic [COORD_WIDTH-1:0]       in_third_x,
  input  logic [COORD_WIDTH-1:0]       in_third_y,
  input  logic [COORD_WIDTH-1:0]       in_third_z,
  input  logic                         in_planar,
  output logic                         out_valid,
  output logic [ANGLE_FRAC_BITS+1:0]   out_angle,
  output logic                         out_degenerate
);

  localparam logic [Z_W-1:0] PI_SUM = PI_Q + (Z_W'(1) << (ZFRAC - ANGLE_FRAC_BITS - 1));
  localparam logic [ANGLE_FRAC_BITS+1:0] PI_OUT = PI_SUM[ZFRAC+1:ZFRAC-ANGLE_FRAC_BITS];

  ctl_t                  ctl_n, ctl_p, ctl_q;
  logic [2:0][VEC_W-1:0] u_vec, v_vec;
  logic [DOT_W-1:0]      dot_p, dot_q;
  logic [CSQ_W-1:0]      csq;
  logic [ROOT_W-1:0]     root;

  assign busy = !rst_n;

  vav_norm #(.CW(COORD_WIDTH)) u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(start && !busy),
    .planar  (in_planar),
    .first   ({in_first_z, in_first_y, in_first_x}),
    .vertex  ({in_vertex_z, in_vertex_y, in_vertex_x}),
    .third   ({in_third_z, in_third_y, in_third_x}),
    .ctl     (ctl_n),
    .u_vec   (u_vec),
    .v_vec   (v_vec)
  );

  vav_prod u_prod (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_in (ctl_n),
    .u_vec  (u_vec),
    .v_vec  (v_vec),
    .ctl_out(ctl_p),
    .dot    (dot_p),
    .csq    (csq)
  );

  vav_isqrt u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_in (ctl_p),
    .dot_in (dot_p),
    .csq    (csq),
    .ctl_out(ctl_q),
    .dot_out(dot_q),
    .root   (root)
  );

  vav_cordic #(.AF(ANGLE_FRAC_BITS)) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl_q),
    .dot       (dot_q),
    .root      (root),
    .out_valid (out_valid),
    .angle     (out_angle),
    .degenerate(out_degenerate)
  );

  `AST_DLY(a_latency, start && !busy, TOTAL_LAT, out_valid)
  `AST_IMP(a_no_invent, out_valid, $past(start && !busy, TOTAL_LAT))
  `AST_IMP(a_degen_zero, out_valid && out_degenerate, out_angle == '0)
  `AST_IMP(a_angle_max, out_valid, out_angle <= PI_OUT)

endmodule
